### rtl/sdaf_pkg.sv
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared types and constants for the signed decimal ASCII formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    // character codes
    localparam logic [7:0] C_CHAR_ZERO  = 8'd48;
    localparam logic [7:0] C_CHAR_MINUS = 8'd45;

    // digit positions, units is position zero
    localparam int unsigned C_DIGIT_COUNT = 10;
    localparam logic [3:0]  C_POS_TOP     = 4'(C_DIGIT_COUNT - 1);
    localparam logic [3:0]  C_MIN_CAP     = 4'(C_DIGIT_COUNT);

    // powers of ten, wide enough to hold nine times the top one
    localparam int unsigned C_THR_W = 36;
    localparam logic [C_THR_W-1:0] C_POW10 [C_DIGIT_COUNT] = '{
        36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
        36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
    };

    // classified item handed from front to back
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic [3:0]  min_digits;
    } t_entry;

    // queue status seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry head;
    } t_queue_head;

endpackage

### rtl/signed_decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter
// Prints a signed 32-bit value as decimal ASCII, one character per item.
// ----------------------------------------------------------------------------
//   channel  direction  fields (tdata / tuser / tlast)
//   s_axis   in         tdata[31:0] value, [35:32] min_digits, [39:36] zero
//   m_axis   out        tdata[7:0] character, tlast last
//
// The back end walks each number over all ten digit positions, with a
// sign step before them for a negative one; skipped leading positions
// give no character.
// A two-entry queue lets the front accept while the back end is busy.
// Reset is synchronous, active low, and clears all valid and busy flags.
// A stalled output holds its character; the walk pauses until it drains.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter
    import sdaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // value[31:0], min_digits[35:32], zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // character[7:0]
    output logic        o_m_axis_tlast
);

    logic        push;
    logic        full;
    logic        pop;
    t_entry      entry;
    t_queue_head head;

    // accept and classify
    sdaf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_value      (i_s_axis_tdata[31:0]),
        .i_min_digits (i_s_axis_tdata[35:32]),
        .o_push       (push),
        .o_entry      (entry),
        .i_full       (full)
    );

    // decoupling queue
    sdaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    // digit walk and output register
    sdaf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

### rtl/sdaf_front.sv
// ----------------------------------------------------------------------------
// sdaf_front
// Accepts items, takes the magnitude and sign and clamps the digit minimum.
// ----------------------------------------------------------------------------
module sdaf_front
    import sdaf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [31:0]  i_value,
    input  logic [3:0]   i_min_digits,
    output logic         o_push,
    output t_entry       o_entry,
    input  logic         i_full
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   accept;

    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid && !i_full;
    assign o_entry = r_entry;

    // classify: sign, magnitude (most negative value wraps to 2^31), clamp
    always_comb begin
        n_entry.neg        = i_value[31];
        n_entry.mag        = i_value[31] ? (~i_value + 32'd1) : i_value;
        n_entry.min_digits = (i_min_digits > C_MIN_CAP) ? C_MIN_CAP : i_min_digits;
    end

    // stage valid
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    a_min_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_entry.min_digits <= C_MIN_CAP))
        else $error("front: minimum not clamped");

    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !accept) |=> !r_valid)
        else $error("front: stage not emptied after push");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_full) |=> (r_valid && $stable(r_entry)))
        else $error("front: held item changed while queue full");

endmodule

### rtl/sdaf_queue.sv
// ----------------------------------------------------------------------------
// sdaf_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module sdaf_queue
    import sdaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_entry      i_entry,
    output logic        o_full,
    input  logic        i_pop,
    output t_queue_head o_head
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_pop;

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.head  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    // pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(i_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue: push while full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue: count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue: pointers disagree with count");

endmodule

### rtl/sdaf_back.sv
// ----------------------------------------------------------------------------
// sdaf_back
// Walks one item from the top digit down, one position a cycle while the
// output is not stalled, and drives the registered character output.
// ----------------------------------------------------------------------------
module sdaf_back
    import sdaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char,
    output logic        o_last
);

    logic        r_busy;
    logic        r_sign_pending;
    logic        r_started;
    logic [3:0]  r_pos;
    logic [3:0]  r_min;
    logic [31:0] r_rem;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    logic        n_busy;
    logic        n_sign_pending;
    logic        n_started;
    logic [3:0]  n_pos;
    logic [3:0]  n_min;
    logic [31:0] n_rem;
    logic        n_out_valid;

    logic                 advance;
    logic                 step;
    logic                 at_units;
    logic                 load;
    logic                 show;
    logic                 emit;
    logic [3:0]           digit;
    logic [C_THR_W-1:0]   rem_wide;
    logic [C_THR_W-1:0]   thr [10];
    logic [C_THR_W-1:0]   sub;

    assign advance  = !r_out_valid || i_ready;
    assign step     = r_busy && advance;
    assign at_units = !r_sign_pending && (r_pos == 4'd0);
    assign load     = i_head.valid && (!r_busy || (step && at_units));
    assign o_pop    = load;

    // digit select: compare against the nine multiples of this position
    always_comb begin
        rem_wide = {4'd0, r_rem};
        for (int m = 0; m < 10; m++) begin
            thr[m] = '0;
        end
        // multiples are constants, picked by the current position
        for (int p = 0; p < C_DIGIT_COUNT; p++) begin
            if (r_pos == 4'(p)) begin
                for (int m = 1; m < 10; m++) begin
                    thr[m] = C_POW10[p] * C_THR_W'(m);
                end
            end
        end
        digit = 4'd0;
        for (int m = 1; m < 10; m++) begin
            if (rem_wide >= thr[m]) begin
                digit = 4'(m);
            end
        end
        sub = rem_wide - thr[digit];
    end

    // a digit is shown at the units position, once the number has started, or when the minimum reaches it
    assign show = (r_pos == 4'd0) || r_started || (digit != 4'd0) || (r_min > r_pos);
    assign emit = step && (r_sign_pending || show);

    // walk state
    always_comb begin
        n_busy         = r_busy;
        n_sign_pending = r_sign_pending;
        n_started      = r_started;
        n_pos          = r_pos;
        n_min          = r_min;
        n_rem          = r_rem;
        if (step) begin
            if (r_sign_pending) begin
                n_sign_pending = 1'b0;
            end else begin
                n_rem     = sub[31:0];
                n_started = r_started || (digit != 4'd0);
                if (at_units) begin
                    n_busy = 1'b0;
                end else begin
                    n_pos = r_pos - 4'd1;
                end
            end
        end
        if (load) begin
            n_busy         = 1'b1;
            n_sign_pending = i_head.head.neg;
            n_started      = 1'b0;
            n_pos          = C_POS_TOP;
            n_min          = i_head.head.min_digits;
            n_rem          = i_head.head.mag;
        end
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_sign_pending <= n_sign_pending;
        r_started      <= n_started;
        r_pos          <= n_pos;
        r_min          <= n_min;
        r_rem          <= n_rem;
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= r_sign_pending ? C_CHAR_MINUS : (C_CHAR_ZERO + {4'd0, digit});
            r_out_last <= !r_sign_pending && at_units;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_pos <= C_POS_TOP) && (r_min <= C_MIN_CAP)))
        else $error("back: position or minimum out of range");

    a_units_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && at_units) |=> (r_out_valid && r_out_last))
        else $error("back: units digit not emitted as last");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_sign_pending) |-> (digit <= 4'd9))
        else $error("back: digit out of range");

    a_no_emit_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !emit)
        else $error("back: character emitted while idle");

endmodule

### verif/tb_signed_decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_signed_decimal_ascii_formatter
// Self-checking bench for the signed decimal ASCII formatter. Numbers go in
// on the slave stream and every character that comes out is compared with a
// local rendering of the same number, including its end-of-run marker. A
// directed set covers the edges of both fields, then random numbers follow
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_signed_decimal_ascii_formatter;
    import sdaf_pkg::*;

    localparam int          IDLE_PCT     = 10;
    localparam int          RANDOM_COUNT = 400;
    localparam int          DRAIN_GUARD  = 20000;
    localparam int          TAIL_CYCLES  = 24;
    localparam longint      RUN_LIMIT    = 3000000;
    localparam logic [3:0]  FLOOR_CAP    = 4'd10;

    // one expected character of a run
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    // expected text store and checker
    class decimal_text_board;
        char_item_t pending_chars[$];
        int         mismatches;
        int         numbers_seen;
        int         chars_checked;
        int         negatives_seen;
        int         padded_runs;

        function new();
            mismatches     = 0;
            numbers_seen   = 0;
            chars_checked  = 0;
            negatives_seen = 0;
            padded_runs    = 0;
        endfunction

        // render the decimal text of one number into the store
        function void note_number(logic [31:0] value, logic [3:0] min_digits);
            logic [31:0] mag;
            logic [31:0] rest;
            logic [3:0]  floor_digits;
            logic [3:0]  digit [C_DIGIT_COUNT];
            int          sig;
            int          pos;
            char_item_t  item;
            numbers_seen++;
            // most negative value wraps to 2^31, which is the right magnitude
            mag          = value[31] ? (~value + 32'd1) : value;
            floor_digits = (min_digits > FLOOR_CAP) ? FLOOR_CAP : min_digits;
            rest = mag;
            sig  = 1;
            for (pos = 0; pos < C_DIGIT_COUNT; pos++) begin
                digit[pos] = 4'(rest % 32'd10);
                rest       = rest / 32'd10;
                if (digit[pos] != 4'd0) sig = pos + 1;
            end
            if (floor_digits > sig) padded_runs++;
            if (value[31]) begin
                negatives_seen++;
                item.ch   = C_CHAR_MINUS;
                item.last = 1'b0;
                pending_chars.push_back(item);
            end
            // a position shows when the magnitude reaches it or the floor covers it
            for (pos = C_DIGIT_COUNT - 1; pos >= 0; pos--) begin
                if (pos < sig || pos < int'(floor_digits)) begin
                    item.ch   = C_CHAR_ZERO + 8'(digit[pos]);
                    item.last = (pos == 0);
                    pending_chars.push_back(item);
                end
            end
        endfunction

        // compare one output character with the oldest expectation
        function void check_char(logic [7:0] ch, logic last);
            char_item_t want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected character: expected none, actual ch=%0d last=%0b",
                         $time, ch, last);
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch) begin
                mismatches++;
                $display("%0t: character mismatch: expected %0d, actual %0d",
                         $time, want.ch, ch);
            end
            if (last !== want.last) begin
                mismatches++;
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata  = '0;   // value[31:0], min_digits[35:32], zero
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;         // character[7:0]
    logic        o_m_axis_tlast;

    logic        calm = 1'b0;
    int          accepted = 0;
    decimal_text_board board = new();

    signed_decimal_ascii_formatter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard limit on run length
    initial begin
        #(RUN_LIMIT);
        $display("%0t: run limit reached", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // monitor both streams and drive random output stalls
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            board.note_number(i_s_axis_tdata[31:0], i_s_axis_tdata[35:32]);
            accepted++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_char(o_m_axis_tdata, o_m_axis_tlast);
        end
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // offer one number and hold it until taken
    task automatic send_number(input logic [31:0] value, input logic [3:0] min_digits);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, min_digits, value};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // random number shaped to hit every digit count and the decade edges
    task automatic send_random_number();
        logic [31:0] mag;
        logic [31:0] value;
        logic [31:0] top;
        logic [3:0]  min_digits;
        int          span;
        int          sel;
        int          k;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            value = $urandom;
        end else begin
            if (sel < 85) begin
                span = $urandom_range(1, 9);
                top  = 32'd1;
                for (k = 0; k < span; k++) top = top * 32'd10;
                mag = $urandom_range(0, top - 32'd1);
            end else begin
                span = $urandom_range(0, 9);
                top  = 32'd1;
                for (k = 0; k < span; k++) top = top * 32'd10;
                mag = top + 32'($urandom_range(0, 2)) - 32'd1;
            end
            value = $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
        end
        min_digits = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
        send_number(value, min_digits);
    endtask

    // stimulus and end of run
    initial begin
        int guard;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, floors, decade edges
        send_number(32'd0, 4'd0);
        send_number(32'd0, 4'd15);
        send_number(32'hFFFF_FFFF, 4'd0);
        send_number(32'd1, 4'd1);
        send_number(32'h7FFF_FFFF, 4'd0);
        send_number(32'h8000_0000, 4'd0);
        send_number(32'h8000_0000, 4'd10);
        send_number(32'h8000_0000, 4'd15);
        send_number(32'd5, 4'd10);
        send_number(32'd5, 4'd11);
        send_number(32'hFFFF_FFFB, 4'd15);
        send_number(32'd123, 4'd2);
        send_number(32'd123, 4'd4);
        send_number(-32'sd7, 4'd3);
        send_number(32'd9, 4'd1);
        send_number(32'd10, 4'd1);
        send_number(32'd999_999_999, 4'd0);
        send_number(32'd1_000_000_000, 4'd0);
        send_number(-32'sd1_000_000_000, 4'd9);
        send_number(32'd100_000_000, 4'd10);
        send_number(32'd42, 4'd9);
        send_number(32'd42, 4'd12);
        send_number(32'hAAAA_AAAA, 4'd5);
        send_number(32'h5555_5555, 4'd10);

        // random: a stretch in the middle runs with no gaps or stalls
        for (n = 0; n < RANDOM_COUNT; n++) begin
            calm <= (n >= 150 && n < 250);
            send_random_number();
        end
        i_s_axis_tvalid <= 1'b0;
        calm            <= 1'b0;

        // drain, then a short tail to catch stray characters
        guard = 0;
        while (board.pending() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.pending() != 0) begin
            board.mismatches++;
            $display("%0t: %0d characters never arrived", $time, board.pending());
        end
        $display("covered %0d numbers (%0d negative, %0d zero-padded), %0d characters checked",
                 accepted, board.negatives_seen, board.padded_runs, board.chars_checked);
        $display("mismatches: %0d", board.mismatches);
        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
